[rtl/hc227_pkg.sv]
// Package for the 3x3 mod-227 Hill cipher block.
// Holds alphabet constants, code mapping functions and shared types.
package hc227_pkg;

  localparam int unsigned Mod = 227;
  localparam logic [7:0] SpaceCode = 8'd4;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_ROW0 = 2'd1,
    CFG_ROW1 = 2'd2,
    CFG_ROW2 = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_INV,
    ST_ADJ,
    ST_MUL,
    ST_EMIT
  } state_e;

  // reduce a product or sum below 2^16 modulo 227 by table-free folding
  function automatic logic [7:0] mod227(input logic [15:0] x);
    logic [16:0] t;
    logic [10:0] u;
    // 256 = 29 mod 227
    t = 17'(x[15:8]) * 17'd29 + 17'(x[7:0]);
    // t < 7651; fold again
    u = 11'(t[16:8]) * 11'd29 + 11'(t[7:0]);
    // u < 1068
    if (u >= 11'd908) u = u - 11'd908;
    else if (u >= 11'd681) u = u - 11'd681;
    else if (u >= 11'd454) u = u - 11'd454;
    else if (u >= 11'd227) u = u - 11'd227;
    return u[7:0];
  endfunction

  function automatic logic [7:0] byte_to_code(input logic [7:0] b);
    logic [7:0] c;
    c = 8'd0;
    if (b == 8'd9) c = 8'd1;
    else if (b == 8'd10) c = 8'd2;
    else if (b == 8'd13) c = 8'd3;
    else if (b >= 8'd32) c = (b == 8'd255) ? 8'd0 : b - 8'd28;
    return c;
  endfunction

  function automatic logic [7:0] code_to_byte(input logic [7:0] c);
    logic [7:0] b;
    if (c == 8'd0) b = 8'd255;
    else if (c == 8'd1) b = 8'd9;
    else if (c == 8'd2) b = 8'd10;
    else if (c == 8'd3) b = 8'd13;
    else b = c + 8'd28;
    return b;
  endfunction

endpackage

[rtl/hc227_mac.sv]
// Shared multiply-accumulate unit mod 227.
// Depends on hc227_pkg.
module hc227_mac (
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] acc_i,
  input  logic       sub_i,
  output logic [7:0] res_o
);
  import hc227_pkg::*;
  logic [7:0] p;
  logic [8:0] s;
  assign p = mod227(16'(a_i) * 16'(b_i));
  always_comb begin
    if (sub_i) s = 9'(acc_i) + 9'd227 - 9'(p);
    else s = 9'(acc_i) + 9'(p);
    if (s >= 9'd227) s = s - 9'd227;
  end
  assign res_o = s[7:0];
endmodule

[rtl/hill_cipher_3x3_mod227.sv]
// Top level of the 3x3 mod-227 Hill cipher.
// Depends on hc227_pkg and hc227_mac.
//
// Usage: bytes arrive on s_axis (tdata = in_byte, tlast = in_last). Every third
// byte, or a byte with tlast, closes a group and the block emits three bytes on
// m_axis (tdata = out_byte, tuser = group_end, message_end, bad_symbol,
// key_singular; tlast is message_end).
// Bytes that do not close a group are stored and the block stays idle. A closing
// byte starts the sequencer, which drives one shared mod-227 multiply-accumulate:
// encrypt takes 9 steps; decrypt adds 18 minor steps, 3 determinant steps,
// 16 inverse-power steps and 9 adjugate scaling steps. The results are written
// in ST_MUL and offered in ST_EMIT, where three output transfers follow, one
// a cycle while m_axis_tready is high. The input is not ready while a group is
// in work or being emitted; a stalled receiver holds the result and the block.
// Reset clears the group, returns every key byte to a space and selects encrypt.
// Configuration goes through cfg_valid_i/cfg_ready_o; it is taken only while
// idle and holds off the input.
module hill_cipher_3x3_mod227 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [3:0]  m_axis_tuser,   // [0] group_end [1] message_end [2] bad_symbol [3] key_singular
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import hc227_pkg::*;

  logic        mode_q;
  logic [23:0] row_q [3];
  logic [7:0]  g_q [3], g_d [3];
  logic [1:0]  fill_q, fill_d;
  logic        bad_q, bad_d, last_q, last_d, sing_q, sing_d;
  state_e      st_q, st_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  acc_q, acc_d;
  logic [7:0]  cof_q [9], cof_d [9];
  logic [7:0]  out_q [3], out_d [3];
  logic [7:0]  base_q, base_d, pw_q, pw_d;
  logic [1:0]  oi_q, oi_d;
  // inverse matrix scratch, written during ST_ADJ
  logic [7:0]  minv_q [9];

  logic [7:0] k [9];
  logic [7:0] ma, mb, macc, mres;
  logic       msub;

  function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
    return {2'b00, r} * 4'd3 + {2'b00, c};
  endfunction

  // row and column of a flat index below 9
  function automatic logic [1:0] quot3(input logic [3:0] v);
    logic [1:0] q;
    if (v >= 4'd6) q = 2'd2;
    else if (v >= 4'd3) q = 2'd1;
    else q = 2'd0;
    return q;
  endfunction

  function automatic logic [1:0] rem3(input logic [3:0] v);
    return 2'(v - {2'b00, quot3(v)} * 4'd3);
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        k[r*3+c] = byte_to_code(row_q[r][c*8 +: 8]);
  end

  hc227_mac u_mac (.a_i(ma), .b_i(mb), .acc_i(macc), .sub_i(msub), .res_o(mres));

  // minor term selection for cofactor n = cnt/2, half h = cnt%2
  logic [3:0] n;
  logic       h;
  logic [1:0] ri, cj, r0, r1, c0, c1;
  assign n  = cnt_q[4:1];
  assign h  = cnt_q[0];
  always_comb begin
    ri = quot3(n);
    cj = rem3(n);
    r0 = (ri == 2'd0) ? 2'd1 : 2'd0;
    r1 = (ri == 2'd2) ? 2'd1 : 2'd2;
    c0 = (cj == 2'd0) ? 2'd1 : 2'd0;
    c1 = (cj == 2'd2) ? 2'd1 : 2'd2;
  end

  // exponent 225 = 8'b11100001, processed MSB first
  localparam logic [7:0] InvExp = 8'd225;
  logic [1:0] mi, mj;
  assign mi = quot3(cnt_q[3:0]);
  assign mj = rem3(cnt_q[3:0]);

  assign cfg_ready_o   = (st_q == ST_IDLE);
  assign s_axis_tready = (st_q == ST_IDLE) && !cfg_valid_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready && (s_axis_tlast || fill_q == 2'd2))
                 st_d = mode_q ? ST_DET : ST_MUL;
      ST_DET:  if (cnt_q == 5'd20) st_d = ST_INV;
      ST_INV:  if (cnt_q == 5'd15) st_d = ST_ADJ;
      ST_ADJ:  if (cnt_q == 5'd8) st_d = ST_MUL;
      ST_MUL:  if (cnt_q == 5'd8) st_d = ST_EMIT;
      ST_EMIT: if (m_axis_tready && oi_q == 2'd2) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    g_d = g_q; fill_d = fill_q; bad_d = bad_q; last_d = last_q; sing_d = sing_q;
    cnt_d = cnt_q + 5'd1; acc_d = acc_q; cof_d = cof_q; out_d = out_q;
    base_d = base_q; pw_d = pw_q; oi_d = oi_q;
    ma = 8'd0; mb = 8'd0; macc = 8'd0; msub = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        cnt_d = 5'd0; acc_d = 8'd0; oi_d = 2'd0; sing_d = 1'b0;
        if (s_axis_tvalid && s_axis_tready) begin
          g_d[fill_q] = byte_to_code(s_axis_tdata);
          if (byte_to_code(s_axis_tdata) == 8'd0 && s_axis_tdata != 8'd255) bad_d = 1'b1;
          last_d = s_axis_tlast;
          fill_d = fill_q + 2'd1;
          if (s_axis_tlast) begin
            if (fill_q == 2'd0) begin g_d[1] = SpaceCode; g_d[2] = SpaceCode; end
            if (fill_q == 2'd1) g_d[2] = SpaceCode;
          end
        end
      end
      ST_DET: begin
        if (cnt_q < 5'd18) begin
          // cofactor minor: a*d then minus b*c
          ma = h ? k[mat_idx(r0, c1)] : k[mat_idx(r0, c0)];
          mb = h ? k[mat_idx(r1, c0)] : k[mat_idx(r1, c1)];
          macc = h ? acc_q : 8'd0;
          msub = h;
          if (h) begin
            cof_d[n] = (ri[0] ^ cj[0]) ? ((mres == 8'd0) ? 8'd0 : 8'(9'd227 - 9'(mres)))
                                       : mres;
            acc_d = 8'd0;
          end else acc_d = mres;
        end else begin
          ma = k[4'(cnt_q - 5'd18)]; mb = cof_q[4'(cnt_q - 5'd18)]; macc = acc_q;
          acc_d = mres;
          if (cnt_q == 5'd20) begin
            base_d = mres; pw_d = 8'd1;
            sing_d = (mres == 8'd0);
          end
        end
        if (cnt_q == 5'd20) cnt_d = 5'd0;
      end
      ST_INV: begin
        // even cnt: square, odd cnt: multiply by base if exponent bit set
        if (!h) begin
          ma = pw_q; mb = pw_q; pw_d = mres;
        end else begin
          ma = pw_q; mb = InvExp[3'd7 - n[2:0]] ? base_q : 8'd1; pw_d = mres;
        end
        if (cnt_q == 5'd15) cnt_d = 5'd0;
      end
      ST_ADJ: begin
        // inverse element (i,j) = cof[j][i] * inv
        ma = cof_q[mat_idx(mj, mi)]; mb = sing_q ? 8'd0 : pw_q;
        if (cnt_q == 5'd8) cnt_d = 5'd0;
      end
      ST_MUL: begin
        ma = g_q[mj]; macc = (mj == 2'd0) ? 8'd0 : acc_q;
        mb = mode_q ? minv_q[cnt_q[3:0]] : k[cnt_q[3:0]];
        acc_d = mres;
        if (mj == 2'd2) out_d[mi] = mres;
        if (cnt_q == 5'd8) cnt_d = 5'd0;
      end
      ST_EMIT: begin
        cnt_d = 5'd0;
        if (m_axis_tready) begin
          oi_d = oi_q + 2'd1;
          if (oi_q == 2'd2) begin
            oi_d = 2'd0;
            fill_d = 2'd0; bad_d = 1'b0; g_d[0] = 8'd0; g_d[1] = 8'd0; g_d[2] = 8'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_ADJ) minv_q[cnt_q[3:0]] <= mres;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; fill_q <= 2'd0; bad_q <= 1'b0; mode_q <= 1'b0;
      row_q[0] <= 24'h202020; row_q[1] <= 24'h202020; row_q[2] <= 24'h202020;
      cnt_q <= 5'd0; oi_q <= 2'd0; sing_q <= 1'b0; last_q <= 1'b0;
      g_q[0] <= 8'd0; g_q[1] <= 8'd0; g_q[2] <= 8'd0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; bad_q <= bad_d; cnt_q <= cnt_d; oi_q <= oi_d;
      sing_q <= sing_d; last_q <= last_d; g_q <= g_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_MODE: mode_q <= cfg_data_i[0];
          CFG_ROW0: row_q[0] <= cfg_data_i;
          CFG_ROW1: row_q[1] <= cfg_data_i;
          CFG_ROW2: row_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; cof_q <= cof_d; out_q <= out_d;
    base_q <= base_d; pw_q <= pw_d;
  end

  assign m_axis_tvalid   = (st_q == ST_EMIT);
  assign m_axis_tdata    = code_to_byte(out_q[oi_q]);
  assign m_axis_tuser[0] = (oi_q == 2'd2);
  assign m_axis_tuser[1] = (oi_q == 2'd2) && last_q;
  assign m_axis_tuser[2] = bad_q;
  assign m_axis_tuser[3] = mode_q && sing_q;
  assign m_axis_tlast    = m_axis_tuser[1];
endmodule

[rtl/hc227_checker.sv]
// Port-level checks for the Hill cipher block, bound to its top level.
// Depends on hill_cipher_3x3_mod227 ports only.
module hc227_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [3:0] m_axis_tuser,
  input logic [7:0] m_axis_tdata
);
  // no new input while a result is offered
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");
  // message end only with group end
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0]) else $error("message end alone");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped");
endmodule

bind hill_cipher_3x3_mod227 hc227_checker u_chk (.*);

[verif/hill_cipher_3x3_mod227_chk.sv]
// Checker for the 3x3 mod-227 Hill cipher: watches config, input and output channels,
// predicts the output bytes and flags, and counts mismatches. Depends on hc227_pkg.
module hill_cipher_3x3_mod227_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [3:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hc227_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       grp_end;
    logic       msg_end;
    logic       bad;
    logic       sing;
  } cipher_out_t;

  cipher_out_t exp_bytes[$];
  logic        decrypt_q;
  logic [23:0] key_rows[3];
  int          codes[3];
  int          fill;
  logic        grp_bad;

  function automatic int sym_code(logic [7:0] b, output logic bad);
    bad = 1'b0;
    if (b == 8'd9) return 1;
    if (b == 8'd10) return 2;
    if (b == 8'd13) return 3;
    if (b >= 8'd32) return (int'(b) - 28) % 227;
    bad = 1'b1;
    return 0;
  endfunction

  function automatic logic [7:0] sym_byte(int c);
    case (c)
      0: return 8'd255;
      1: return 8'd9;
      2: return 8'd10;
      3: return 8'd13;
      default: return 8'(c + 28);
    endcase
  endfunction

  task automatic encipher_group(logic last);
    int k[3][3];
    int m[3][3];
    int cof[3][3];
    int det, inv, b, e, acc, r0, r1, c0, c1, mn;
    logic dummy, sing;
    cipher_out_t o;
    sing = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        k[i][j] = sym_code(key_rows[i][8*j +: 8], dummy);
    if (decrypt_q) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          r0 = (i == 0) ? 1 : 0;
          r1 = (i == 2) ? 1 : 2;
          c0 = (j == 0) ? 1 : 0;
          c1 = (j == 2) ? 1 : 2;
          mn = (k[r0][c0] * k[r1][c1] - k[r0][c1] * k[r1][c0]) % 227;
          if (mn < 0) mn += 227;
          cof[i][j] = ((i + j) % 2) ? (227 - mn) % 227 : mn;
        end
      det = (k[0][0] * cof[0][0] + k[0][1] * cof[0][1] + k[0][2] * cof[0][2]) % 227;
      inv = 1;
      b = det;
      e = 225;
      while (e != 0) begin
        if (e % 2) inv = inv * b % 227;
        b = b * b % 227;
        e /= 2;
      end
      if (det == 0) inv = 0;
      sing = (det == 0);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = cof[j][i] * inv % 227;
    end else begin
      m = k;
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc = (acc + m[i][j] * codes[j]) % 227;
      o.data    = sym_byte(acc);
      o.grp_end = (i == 2);
      o.msg_end = (i == 2) && last;
      o.bad     = grp_bad;
      o.sing    = sing;
      exp_bytes.push_back(o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_out_t e;
    logic bad;
    if (!rst_ni) begin
      decrypt_q  <= 1'b0;
      key_rows   = '{24'h202020, 24'h202020, 24'h202020};
      fill       = 0;
      grp_bad    = 1'b0;
      fail_cnt_o <= 0;
      exp_bytes.delete();
      pending_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE: decrypt_q <= cfg_data_i[0];
          CFG_ROW0: key_rows[0] = cfg_data_i;
          CFG_ROW1: key_rows[1] = cfg_data_i;
          CFG_ROW2: key_rows[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        codes[fill] = sym_code(s_axis_tdata, bad);
        fill++;
        if (bad) grp_bad = 1'b1;
        if (fill == 3 || s_axis_tlast) begin
          // pad a short last group with spaces
          while (fill < 3) begin
            codes[fill] = int'(SpaceCode);
            fill++;
          end
          encipher_group(s_axis_tlast);
          fill    = 0;
          grp_bad = 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_bytes.size() == 0) begin
          $error("unexpected output transfer data=%0d", m_axis_tdata);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = exp_bytes.pop_front();
          if (m_axis_tdata !== e.data || m_axis_tuser[0] !== e.grp_end
              || m_axis_tuser[1] !== e.msg_end || m_axis_tlast !== e.msg_end
              || m_axis_tuser[2] !== e.bad || m_axis_tuser[3] !== e.sing)
            fail_cnt_o <= fail_cnt_o + 1;
          if (m_axis_tdata !== e.data)
            $error("out_byte expected %0d actual %0d", e.data, m_axis_tdata);
          if (m_axis_tuser[0] !== e.grp_end)
            $error("group_end expected %0d actual %0d", e.grp_end, m_axis_tuser[0]);
          if (m_axis_tuser[1] !== e.msg_end)
            $error("message_end expected %0d actual %0d", e.msg_end, m_axis_tuser[1]);
          if (m_axis_tlast !== e.msg_end)
            $error("tlast expected %0d actual %0d", e.msg_end, m_axis_tlast);
          if (m_axis_tuser[2] !== e.bad)
            $error("bad_symbol expected %0d actual %0d", e.bad, m_axis_tuser[2]);
          if (m_axis_tuser[3] !== e.sing)
            $error("key_singular expected %0d actual %0d", e.sing, m_axis_tuser[3]);
        end
      end
      pending_o <= exp_bytes.size();
    end
  end
endmodule

[verif/hill_cipher_3x3_mod227_tb.sv]
// Testbench top for the 3x3 mod-227 Hill cipher: drives bytes and key settings,
// stalls both sides at random. Depends on hc227_pkg, the block and its checker.
module hill_cipher_3x3_mod227_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hc227_pkg::*;

  localparam int IdleLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  int          fail_cnt;
  int          pending;
  int          idle_cycles = 0;
  int          sink_idle_pct = 15;
  logic        sink_hold = 1'b0;

  hill_cipher_3x3_mod227 DUT (.*);

  hill_cipher_3x3_mod227_chk u_chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_key(logic dec, logic [23:0] r0, logic [23:0] r1, logic [23:0] r2);
    write_reg(CFG_MODE, {23'b0, dec});
    write_reg(CFG_ROW0, r0);
    write_reg(CFG_ROW1, r1);
    write_reg(CFG_ROW2, r2);
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'($urandom_range(31));
      1: return 8'd9;
      2: return 8'd10;
      3: return 8'd13;
      4: return 8'd255;
      default: return 8'($urandom_range(255, 32));
    endcase
  endfunction

  task automatic random_messages(int n, int idle_pct);
    int len;
    while (n > 0) begin
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(pick_byte(), (i == len - 1) || ($urandom_range(19) == 0), idle_pct);
        n--;
      end
    end
  endtask

  initial begin
    logic [7:0] edge_bytes[12];
    edge_bytes = '{8'd0, 8'd9, 8'd10, 8'd13, 8'd31, 8'd32, 8'd254, 8'd255,
                   8'd1, 8'd12, 8'd128, 8'd127};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key (all spaces, singular for decrypt) in encrypt mode
    foreach (edge_bytes[i]) send_byte(edge_bytes[i], i == 7, 0);
    send_byte(8'd65, 1'b1, 0);
    send_byte(8'd66, 1'b0, 0);
    send_byte(8'd67, 1'b1, 0);
    drain();

    set_key(1'b1, 24'h202020, 24'h202020, 24'h202020);
    send_byte(8'd72, 1'b0, 0);
    send_byte(8'd0, 1'b1, 0);
    drain();

    // invertible key: identity-like codes (byte 9 -> code 1, byte 0 -> code 0)
    set_key(1'b0, 24'h000009, 24'h000900, 24'h090000);
    random_messages(30, 15);
    drain();
    set_key(1'b0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    random_messages(20, 15);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_key(ph[0], 24'($urandom), 24'($urandom), 24'($urandom));
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps pushing
        sink_hold <= 1'b1;
        fork
          begin
            random_messages(40, 0);
            s_axis_tvalid <= 1'b0;
          end
          begin
            repeat (300) @(posedge clk_i);
            sink_hold <= 1'b0;
          end
        join
      end else if (ph == 3) begin
        sink_idle_pct <= 0;
        random_messages(50, 0);
        sink_idle_pct <= 15;
      end else begin
        random_messages(45, 15);
      end
      drain();
    end

    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
